FILE: hw/rtl/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

    localparam int WORD_W     = 32;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int FILL_W     = 5;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - WORD_W - FILL_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 2'd0,
        REQ_PUSH_FRONT = 2'd1,
        REQ_POP_BACK   = 2'd2,
        REQ_POP_FRONT  = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

FILE: hw/rtl/dq_ram.sv
`timescale 1ns / 1ps

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/dq_ctrl.sv
`timescale 1ns / 1ps

module dq_ctrl
    import dq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t dp_stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_BUSY;
                end
            end
            S_BUSY: begin
                // wait until the output register can take the result
                if (!dp_stat.out_busy) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

FILE: hw/rtl/dq_datapath.sv
`timescale 1ns / 1ps

module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            dp_stat,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [REQ_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]   m_tuser
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    // operand is below twice the depth
    function automatic logic [AW-1:0] wrap_pos(input logic [AW:0] pos);
        logic [AW:0] diff;
        diff = pos - DEPTH_X;
        wrap_pos = (pos >= DEPTH_X) ? diff[AW-1:0] : pos[AW-1:0];
    endfunction

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    status_t       pend_status_reg, pend_status_next;
    logic          pend_pop_reg, pend_pop_next;

    logic                 out_valid_reg;
    logic [WORD_W-1:0]    out_word_reg;
    status_t              out_status_reg;
    logic [FILL_W-1:0]    out_fill_reg;

    logic                 full, empty;
    logic [AW:0]          head_x, cnt_x;
    logic [AW-1:0]        back_pos, last_pos, front_dec, front_inc;
    logic                 wr_en, rd_en;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic [WORD_W-1:0]    rd_data;

    assign full      = (count_reg == DEPTH_C);
    assign empty     = (count_reg == '0);
    assign head_x    = {1'b0, head_reg};
    assign cnt_x     = (AW + 1)'(count_reg);
    assign back_pos  = wrap_pos(head_x + cnt_x);
    assign last_pos  = wrap_pos(head_x + cnt_x - (AW + 1)'(1));
    assign front_dec = (head_reg == '0) ? LAST_IDX : head_reg - AW'(1);
    assign front_inc = wrap_pos(head_x + (AW + 1)'(1));

    always_comb begin
        head_next        = head_reg;
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        pend_pop_next    = pend_pop_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        wr_addr          = back_pos;
        rd_addr          = head_reg;
        if (cmd.accept) begin
            pend_status_next = ST_OK;
            pend_pop_next    = 1'b0;
            case (req_t'(s_tuser))
                REQ_PUSH_BACK: begin
                    if (full) begin
                        pend_status_next = ST_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = back_pos;
                        count_next = count_reg + CW'(1);
                    end
                end
                REQ_PUSH_FRONT: begin
                    if (full) begin
                        pend_status_next = ST_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                        head_next  = front_dec;
                        count_next = count_reg + CW'(1);
                    end
                end
                REQ_POP_BACK: begin
                    if (empty) begin
                        pend_status_next = ST_EMPTY;
                    end else begin
                        rd_en         = 1'b1;
                        rd_addr       = last_pos;
                        pend_pop_next = 1'b1;
                        count_next    = count_reg - CW'(1);
                    end
                end
                REQ_POP_FRONT: begin
                    if (empty) begin
                        pend_status_next = ST_EMPTY;
                    end else begin
                        rd_en         = 1'b1;
                        rd_addr       = head_reg;
                        head_next     = front_inc;
                        pend_pop_next = 1'b1;
                        count_next    = count_reg - CW'(1);
                    end
                end
                default: begin
                    pend_status_next = ST_OK;
                end
            endcase
        end
    end

    dq_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(s_tdata[WORD_W-1:0]),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg        <= '0;
            count_reg       <= '0;
            pend_status_reg <= ST_OK;
            pend_pop_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            head_reg        <= head_next;
            count_reg       <= count_next;
            pend_status_reg <= pend_status_next;
            pend_pop_reg    <= pend_pop_next;
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // count does not move between accept and load
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_word_reg   <= pend_pop_reg ? rd_data : '0;
            out_status_reg <= pend_status_reg;
            out_fill_reg   <= FILL_W'(count_reg);
        end
    end

    assign dp_stat.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_fill_reg, out_word_reg};
    assign m_tuser  = out_status_reg;

endmodule

FILE: hw/rtl/double_ended_queue_core.sv
// double-ended queue of 32-bit words, one request per word in, one result word out
// the store read is registered, then moved into the output register once that register is free
// one request at a time: the next is taken only once the result is in the output register
// a finished result may wait in the output register while the next request is taken
// reset: synchronous active-low aresetn empties the queue and clears the handshake state
`timescale 1ns / 1ps

module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // push_word[31:0]
    input  logic [REQ_W-1:0]      s_tuser,   // req_type[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // pop_word[31:0], fill_count[36:32], zero pad
    output logic [STATUS_W-1:0]   m_tuser    // status[1:0]
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_stat;

    dq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .dp_stat (dp_stat),
        .cmd     (cmd)
    );

    dq_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .dp_stat (dp_stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // one request in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in flight");

    // failed requests never return a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_EMPTY)) |-> (m_tdata[WORD_W-1:0] == '0))
        else $error("error result carries a nonzero word");

    // fill level never exceeds capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[WORD_W+FILL_W-1:WORD_W]) <= 32'(DEPTH)))
        else $error("fill count beyond capacity");

    // an empty report means nothing is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[WORD_W+FILL_W-1:WORD_W] == '0))
        else $error("empty status with words held");

endmodule
